FILE: hw/rtl/lird_pkg.sv
// Shared types and constants for the inclusive range draw block.
`default_nettype none
package lird_pkg;
    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] t_word;

    // Linear congruential generator constants
    localparam t_word LCG_MUL   = 32'd1103515245;
    localparam t_word LCG_ADD   = 32'd12345;
    localparam int    LCG_SHIFT = 16;
    localparam t_word LCG_MASK  = 32'h0000_7FFF;
endpackage
`default_nettype wire

FILE: hw/rtl/lird_lcg.sv
// Seed register and one-step linear congruential update.
`default_nettype none
module lird_lcg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  wire lird_pkg::t_word i_load_value,
    input  wire logic           i_step,
    output lird_pkg::t_word     o_draw
);
    import lird_pkg::*;

    t_word r_seed;
    t_word n_seed;

    // Seed update: a configuration write wins, otherwise step on request
    always_comb begin
        n_seed = r_seed;
        if (i_load) begin
            n_seed = i_load_value;
        end else if (i_step) begin
            n_seed = r_seed * LCG_MUL + LCG_ADD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else begin
            r_seed <= n_seed;
        end
    end

    // 15-bit draw from the upper half of the seed
    assign o_draw = (r_seed >> LCG_SHIFT) & LCG_MASK;
endmodule
`default_nettype wire

FILE: hw/rtl/lird_div.sv
// Radix-2 restoring divider that returns the unsigned remainder.
`default_nettype none
module lird_div (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire lird_pkg::t_word i_num,
    input  wire lird_pkg::t_word i_den,
    output logic                o_done,
    output lird_pkg::t_word     o_rem
);
    import lird_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_word            r_num;
    t_word            r_den;
    t_word            r_rem;

    t_word           rem_shift;
    logic [WORD_W:0] diff;

    // One quotient bit per cycle: shift in a numerator bit, try to subtract
    assign rem_shift = {r_rem[WORD_W-2:0], r_num[WORD_W-1]};
    assign diff      = {1'b0, rem_shift} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[WORD_W-2:0], 1'b0};
            r_rem <= diff[WORD_W] ? rem_shift : diff[WORD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

FILE: hw/rtl/lcg_inclusive_range_draw_top.sv
// Top level of the inclusive range draw: sequencer, LCG and shared divider.
//
//  channel | direction | signals                                       | handshake
//  --------+-----------+-----------------------------------------------+-----------------------
//  in      | input     | op, range_min, range_max, supplied_draw       | i_in_valid / o_in_ready
//  out     | output    | chosen_value, zero_width_error                | o_out_valid / i_out_ready
//  cfg     | input     | cfg_data (initial seed)                       | i_cfg_valid / o_cfg_ready
//
// Equal endpoints: result is valid in the cycle after the input transaction.
// Zero width: the item passes through the prep state, then the result is valid.
// Otherwise: setup, 32 steps of the radix-2 remainder divider, finish.
// One item at a time; o_in_ready is high only while idle, and a stalled result
// holds the block until the output transaction. Reset is synchronous and loads
// seed 0; a configuration write loads the seed at once.
`default_nettype none
module lcg_inclusive_range_draw_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_op,
    input  wire logic signed [31:0]   i_range_min,
    input  wire logic signed [31:0]   i_range_max,
    input  wire lird_pkg::t_word      i_supplied_draw,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic signed [31:0]        o_chosen_value,
    output logic                      o_zero_width_error,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire lird_pkg::t_word      i_cfg_data
);
    import lird_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    t_word r_min;
    t_word r_width;
    t_word r_sup;
    logic  r_op;
    logic  r_nneg;
    t_word r_chosen;
    logic  r_err;

    logic  in_xact;
    logic  out_xact;
    logic  cfg_xact;
    logic  ends_equal;
    logic  lcg_step;
    t_word lcg_draw;
    t_word draw;
    t_word num_mag;
    t_word den_mag;
    logic  div_start;
    logic  div_done;
    t_word div_rem;

    assign in_xact  = i_in_valid && o_in_ready;
    assign out_xact = o_out_valid && i_out_ready;
    assign cfg_xact = i_cfg_valid && o_cfg_ready;

    assign ends_equal = (i_range_min == i_range_max);
    // Generator steps only for a real draw in mode 0
    assign lcg_step   = in_xact && !ends_equal && !i_op;

    lird_lcg u_lcg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (cfg_xact),
        .i_load_value (i_cfg_data),
        .i_step       (lcg_step),
        .o_draw       (lcg_draw)
    );

    // Operand magnitudes for the divider
    assign draw      = r_op ? r_sup : lcg_draw;
    assign num_mag   = draw[WORD_W-1] ? (t_word'(0) - draw) : draw;
    assign den_mag   = r_width[WORD_W-1] ? (t_word'(0) - r_width) : r_width;
    assign div_start = (r_state == S_PREP) && (r_width != '0);

    lird_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_mag),
        .i_den   (den_mag),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xact) begin
                    n_state = ends_equal ? S_OUT : S_PREP;
                end
            end
            S_PREP: begin
                n_state = (r_width == '0) ? S_OUT : S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_xact) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Item capture and result registers
    always_ff @(posedge i_clk) begin
        if (in_xact) begin
            r_min    <= t_word'(i_range_min);
            r_width  <= t_word'(i_range_max) - t_word'(i_range_min) + t_word'(1);
            r_sup    <= i_supplied_draw;
            r_op     <= i_op;
            r_chosen <= t_word'(i_range_min);
            r_err    <= 1'b0;
        end
        if (r_state == S_PREP) begin
            r_nneg <= draw[WORD_W-1];
            if (r_width == '0) begin
                r_chosen <= '0;
                r_err    <= 1'b1;
            end
        end
        if ((r_state == S_DIV) && div_done) begin
            r_chosen <= r_nneg ? (r_min - div_rem) : (r_min + div_rem);
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = (r_state == S_OUT);
    assign o_chosen_value     = r_chosen;
    assign o_zero_width_error = r_err;
    assign o_cfg_ready        = 1'b1;
endmodule
`default_nettype wire

FILE: hw/rtl/lird_checker.sv
// Port-level checker for the inclusive range draw, bound to the top level.
`default_nettype none
module lird_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic signed [31:0] o_chosen_value,
    input wire logic               o_zero_width_error
);
    // A waiting result holds until its transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_chosen_value)
            && $stable(o_zero_width_error)))
        else $error("result changed while stalled");

    // One item at a time: never ready while a result is pending
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while result pending");

    // An accepted item closes the input side
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after a transaction");

    // Delivering the result reopens the input side
    a_idle_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> (o_in_ready && !o_out_valid))
        else $error("block not idle after output transaction");

    // Zero-width error carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_width_error) |-> (o_chosen_value == 0))
        else $error("zero-width error with nonzero value");
endmodule

bind lcg_inclusive_range_draw_top lird_checker u_lird_checker (.*);
`default_nettype wire

FILE: tb/lcg_inclusive_range_draw_top_test.sv
// Testbench for the inclusive range draw block: random and directed draws checked by a scoreboard.
`timescale 1ns / 1ps
module lcg_inclusive_range_draw_top_test;
    import lird_pkg::*;

    // Draw source selector carried in the op field
    localparam bit OP_GENERATOR = 1'b0;
    localparam bit OP_SUPPLIED  = 1'b1;

    localparam t_word INT_MIN = 32'h8000_0000;
    localparam t_word INT_MAX = 32'h7FFF_FFFF;
    localparam t_word ALL_ONES = 32'hFFFF_FFFF;

    localparam int unsigned CYCLE_LIMIT   = 400_000;
    localparam int unsigned PHASE_ITEMS   = 170;
    localparam int unsigned SETTLE_CYCLES = 40;

    typedef struct {
        t_word value;
        bit    zero_width;
    } t_draw_result;

    // Tracks the generator seed and the queue of draws still owed by the block
    class t_range_draw_checker;
        t_word        gen_seed = '0;
        t_draw_result expected_draws[$];
        int unsigned  fail_count = 0;

        function void load_seed(t_word seed);
            gen_seed = seed;
        endfunction

        function int pending();
            return expected_draws.size();
        endfunction

        // Truncating signed remainder on raw 32-bit patterns; den is nonzero
        function t_word signed_rem(t_word num, t_word den);
            t_word nmag;
            t_word dmag;
            t_word r;
            nmag = num[31] ? 32'd0 - num : num;
            dmag = den[31] ? 32'd0 - den : den;
            r = nmag % dmag;
            return num[31] ? 32'd0 - r : r;
        endfunction

        // Accepted input transaction: work out the draw it must produce
        function void note_request(bit op, t_word lo, t_word hi, t_word sup);
            t_draw_result want;
            t_word        draw;
            t_word        width;
            want.value = '0;
            want.zero_width = 1'b0;
            if (lo == hi) begin
                // equal endpoints: no seed step
                want.value = lo;
            end else begin
                if (op == OP_GENERATOR) begin
                    gen_seed = gen_seed * LCG_MUL + LCG_ADD;
                    draw = (gen_seed >> LCG_SHIFT) & LCG_MASK;
                end else begin
                    draw = sup;
                end
                width = hi - lo + 32'd1;
                if (width == '0) begin
                    want.zero_width = 1'b1;
                end else begin
                    want.value = lo + signed_rem(draw, width);
                end
            end
            expected_draws.push_back(want);
        endfunction

        // Output transaction: compare with the oldest owed draw
        function void check_draw(t_word value, bit zero_width);
            t_draw_result want;
            if (expected_draws.size() == 0) begin
                $display("%0t: unexpected result chosen_value=%0d zero_width_error=%0b",
                         $time, $signed(value), zero_width);
                fail_count++;
                return;
            end
            want = expected_draws.pop_front();
            if (value !== want.value) begin
                $display("%0t: chosen_value mismatch, expected %0d got %0d",
                         $time, $signed(want.value), $signed(value));
                fail_count++;
            end
            if (zero_width !== want.zero_width) begin
                $display("%0t: zero_width_error mismatch, expected %0b got %0b",
                         $time, want.zero_width, zero_width);
                fail_count++;
            end
        endfunction
    endclass

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_op = OP_GENERATOR;
    t_word in_min = '0;
    t_word in_max = '0;
    t_word in_sup = '0;
    logic  out_ready = 1'b0;
    logic  cfg_valid = 1'b0;
    t_word cfg_data = '0;

    logic               o_in_ready;
    logic               o_out_valid;
    logic signed [31:0] o_chosen_value;
    logic               o_zero_width_error;
    logic               o_cfg_ready;

    bit          steady_flow = 1'b0;
    int unsigned cycle_count = 0;

    t_range_draw_checker chk = new();

    lcg_inclusive_range_draw_top dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (in_op),
        .i_range_min       (in_min),
        .i_range_max       (in_max),
        .i_supplied_draw   (in_sup),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_chosen_value    (o_chosen_value),
        .o_zero_width_error(o_zero_width_error),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (cfg_data)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result monitor
    always @(posedge clk) begin
        if (rst_n && o_out_valid === 1'b1 && out_ready) begin
            chk.check_draw(o_chosen_value, o_zero_width_error);
        end
    end

    // Result sink with random back-pressure, none while the flow is steady
    initial begin : result_sink
        int unsigned stall;
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(rst_n && o_out_valid === 1'b1));
        end
    end

    // One input transaction after a random gap, none while the flow is steady
    task automatic send_item(input bit op, input t_word lo, input t_word hi, input t_word sup);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_min   <= lo;
        in_max   <= hi;
        in_sup   <= sup;
        do @(posedge clk); while (o_in_ready !== 1'b1);
        chk.note_request(op, lo, hi, sup);
    endtask

    // Hold off the sender until every owed draw has come back
    task automatic drain();
        if (chk.pending() != 0) begin
            in_valid <= 1'b0;
            while (chk.pending() != 0) @(posedge clk);
        end
    endtask

    // Seed write; only called with the block idle
    task automatic write_seed(input t_word seed);
        cfg_valid <= 1'b1;
        cfg_data  <= seed;
        do @(posedge clk); while (o_cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        chk.load_seed(seed);
    endtask

    function automatic t_word pick_corner();
        case ($urandom_range(0, 6))
            0: return INT_MIN;
            1: return INT_MAX;
            2: return '0;
            3: return ALL_ONES;
            4: return 32'd1;
            5: return INT_MIN + 32'd1;
            default: return INT_MAX - 32'd1;
        endcase
    endfunction

    function automatic t_word pick_supplied();
        int unsigned roll;
        roll = $urandom_range(0, 7);
        if (roll == 0) begin
            return pick_corner();
        end else if (roll == 1) begin
            return t_word'($urandom_range(0, 32'h7FFF));
        end
        return $urandom();
    endfunction

    function automatic t_word pick_small();
        return t_word'($urandom_range(0, 2000)) - 32'd1000;
    endfunction

    // Random item: mostly ordinary ranges, plus equal, zero-width, wide and corner ranges
    task automatic send_random_item();
        int unsigned roll;
        bit          op;
        t_word       lo;
        t_word       hi;
        roll = $urandom_range(0, 19);
        op = 1'($urandom_range(0, 1));
        if (roll < 2) begin
            lo = $urandom();
            hi = lo;
        end else if (roll < 4) begin
            lo = $urandom();
            hi = lo - 32'd1;
        end else if (roll < 7) begin
            lo = $urandom();
            hi = lo + t_word'($urandom_range(0, 300)) - 32'd150;
        end else if (roll < 10) begin
            lo = $urandom();
            hi = $urandom();
        end else if (roll < 12) begin
            lo = pick_corner();
            hi = pick_corner();
        end else begin
            lo = pick_small();
            hi = pick_small();
        end
        send_item(op, lo, hi, pick_supplied());
    endtask

    initial begin : stimulus
        t_word phase_seed;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, running from the reset seed
        send_item(OP_GENERATOR, 32'd0, 32'd9, 32'h1234_5678);
        send_item(OP_GENERATOR, 32'd0, 32'd32767, ALL_ONES);
        send_item(OP_SUPPLIED, -32'sd5, 32'd5, INT_MIN);
        send_item(OP_SUPPLIED, -32'sd7, 32'd7, '0);
        send_item(OP_SUPPLIED, -32'sd7, 32'd7, ALL_ONES);
        // equal endpoints, both modes
        send_item(OP_GENERATOR, 32'd123, 32'd123, $urandom());
        send_item(OP_SUPPLIED, INT_MIN, INT_MIN, $urandom());
        send_item(OP_SUPPLIED, INT_MAX, INT_MAX, ALL_ONES);
        send_item(OP_GENERATOR, 32'd0, 32'd3, '0);
        // zero width: generator still steps
        send_item(OP_GENERATOR, 32'd0, ALL_ONES, '0);
        send_item(OP_GENERATOR, 32'd0, 32'd3, '0);
        send_item(OP_SUPPLIED, INT_MIN, INT_MAX, 32'd77);
        // width of minus one with the most negative draw
        send_item(OP_SUPPLIED, 32'd5, 32'd3, INT_MIN);
        send_item(OP_GENERATOR, INT_MIN, INT_MAX - 32'd1, $urandom());
        // reversed and wrapping ranges
        send_item(OP_GENERATOR, 32'd100, -32'sd100, '0);
        send_item(OP_SUPPLIED, INT_MAX, INT_MIN, ALL_ONES);
        send_item(OP_SUPPLIED, ALL_ONES, INT_MAX, INT_MAX);
        send_item(OP_SUPPLIED, 32'd0, INT_MAX, ALL_ONES);
        send_item(OP_SUPPLIED, 32'd0, INT_MAX, INT_MIN);
        send_item(OP_SUPPLIED, 32'd0, 32'd1, INT_MAX);
        send_item(OP_GENERATOR, INT_MIN, INT_MIN + 32'd1, '0);
        send_item(OP_GENERATOR, ALL_ONES, 32'd0, '0);
        send_item(OP_SUPPLIED, INT_MIN, INT_MAX - 32'd1, $urandom());
        drain();

        // Random phases, each with its own seed
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: phase_seed = ALL_ONES;
                1: phase_seed = '0;
                2: phase_seed = INT_MIN;
                default: phase_seed = $urandom();
            endcase
            write_seed(phase_seed);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 30 == 0) begin
                    steady_flow = ($urandom_range(0, 3) == 0);
                end
                if ($urandom_range(0, 59) == 0) begin
                    drain();
                end
                send_random_item();
            end
            drain();
        end

        steady_flow = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (chk.fail_count == 0 && chk.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
